>>> src/set_associative_cache_model_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache model
// Shared shorthand for the concurrent checks on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOCIATIVE_CACHE_MODEL_TOP_MACROS_SVH
`define SET_ASSOCIATIVE_CACHE_MODEL_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SACM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sacm check failed");

// Next-cycle implication, checked outside reset.
`define SACM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sacm check failed");

`endif

>>> src/sacm_pkg.sv
// ----------------------------------------------------------------------------
// Set-associative cache model package
// Item types, register indexes, access kinds and policy codes.
// ----------------------------------------------------------------------------
package sacm_pkg;

  localparam int ADDR_BITS = 32;
  localparam int CFG_W     = 16;

  // Register indexes on the write port.
  localparam logic [2:0] CFG_LINE_SIZE = 3'd0;
  localparam logic [2:0] CFG_SETS      = 3'd1;
  localparam logic [2:0] CFG_WAYS      = 3'd2;
  localparam logic [2:0] CFG_POLICY    = 3'd3;
  localparam logic [2:0] CFG_WB_MODE   = 3'd4;
  localparam logic [2:0] CFG_DECAY     = 3'd5;

  // Access kinds.
  localparam logic [1:0] KIND_STORE = 2'd2;

  // Replacement policies.
  localparam logic [1:0] POL_FIFO   = 2'd0;
  localparam logic [1:0] POL_LRU    = 2'd1;
  localparam logic [1:0] POL_LFU    = 2'd2;
  localparam logic [1:0] POL_RANDOM = 2'd3;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [31:0] address;
    logic [6:0]  length;
  } in_t;

  typedef struct packed {
    logic [31:0] line_address;
    logic        hit;
    logic [2:0]  way;
    logic        dirty_eviction;
    logic        through_write;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] memory_read_total;
    logic [31:0] memory_write_total;
  } out_t;

endpackage

>>> src/set_associative_cache_model_top.sv
// ----------------------------------------------------------------------------
// Set-associative cache model
// Looks up each reference in a set-associative tag store and reports hits,
// fills, evictions and running memory traffic counts.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_data (in_t)
// out     | output    | out_valid / out_ready| out_data (out_t)
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A line access reads the set row, scans the ways in use in turn, then takes
// a decide step and an update step; a random victim adds a pass through the
// shared remainder unit. Under LFU each reference adds a remainder pass, and a
// decay sweep reads and writes back every row of the single-port row memory.
// After reset a clearing pass over all MAX_SETS rows runs before the first item.
// A full output register holds the sequencer in its update step.
// ----------------------------------------------------------------------------
module set_associative_cache_model_top
  import sacm_pkg::*;
#(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W  = $clog2(MAX_WAYS + 1);

  typedef struct packed {
    logic [MAX_WAYS-1:0]                valid;
    logic [MAX_WAYS-1:0]                dirty;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
    logic [MAX_WAYS-1:0][31:0]          rank;
  } row_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DMOD, S_LREAD, S_SCAN, S_DECIDE, S_RMOD, S_UPDATE,
    S_SWRD, S_SWWR
  } state_t;

  // Configuration registers.
  logic [2:0]  line_size_log2;
  logic [2:0]  sets_log2;
  logic [3:0]  ways_in_use;
  logic [1:0]  victim_policy;
  logic        wb_mode;
  logic [15:0] decay_interval;

  // Sequencer and item state.
  state_t              state;
  logic [SET_W-1:0]    sweep_idx;
  logic [1:0]          kind_q;
  logic [31:0]         line_cur;
  logic [31:0]         line_second;
  logic                last_q;
  logic                decay_due;
  logic [SET_W-1:0]    set_q;
  logic [WAY_W-1:0]    scan_w;
  logic                hit_f;
  logic [WAY_W-1:0]    hit_w;
  logic                inv_f;
  logic [WAY_W-1:0]    inv_w;
  logic [WAY_W-1:0]    min_w;
  logic [31:0]         best_rank;
  logic [WAY_W-1:0]    way_q;
  logic [31:0]         reference_count;
  logic [31:0]         hit_count;
  logic [31:0]         miss_count;
  logic [31:0]         read_count;
  logic [31:0]         write_count;
  logic [31:0]         random_state;

  // Shared remainder unit.
  logic [31:0] mod_dvd;
  logic [15:0] mod_div;
  logic [15:0] mod_rem;
  logic [3:0]  mod_cnt;
  logic [31:0] mod_dvd_next;
  logic [15:0] mod_rem_next;
  logic [16:0] mod_t;

  // Row memory.
  row_t             mem [MAX_SETS];
  row_t             rd_row;
  row_t             wr_row;
  row_t             upd_row;
  row_t             half_row;
  logic             mem_we;
  logic             mem_re;
  logic [SET_W-1:0] mem_addr;

  // Combinational helpers.
  logic [4:0]        nw_full;
  logic [NW_W-1:0]   nw;
  logic [15:0]       iv;
  logic [6:0]        len_eff;
  logic [31:0]       lmask;
  logic [31:0]       in_l1;
  logic [31:0]       in_l2;
  logic [31:0]       ref_inc;
  logic [6:0]        set_raw;
  logic [SET_W-1:0]  set_tab [128];
  logic              scan_last;
  logic              scan_match;
  logic              is_store;
  logic              wb;
  logic              out_free;
  logic              dev;
  logic              tw;
  logic [31:0]       rnd_next;

  // Set index table: raw index modulo the store depth.
  for (genvar g = 0; g < 128; g++) begin : g_set_tab
    assign set_tab[g] = SET_W'(g % MAX_SETS);
  end

  // Decode of the item and of the registers.
  always_comb begin
    nw_full = (ways_in_use == 4'd0) ? 5'd1 :
              ((5'(ways_in_use) > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : 5'(ways_in_use));
    nw      = NW_W'(nw_full);
    iv      = (decay_interval == 16'd0) ? 16'd1 : decay_interval;
    len_eff = (in_data.length == 7'd0) ? 7'd1 : in_data.length;
    lmask   = ~((32'd1 << line_size_log2) - 32'd1);
    in_l1   = in_data.address & lmask;
    in_l2   = (in_data.address + 32'(len_eff) - 32'd1) & lmask;
    ref_inc = reference_count + 32'd1;
    set_raw = 7'((line_cur >> line_size_log2) & ((32'd1 << sets_log2) - 32'd1));
    is_store = (kind_q == KIND_STORE);
    wb       = wb_mode;
    out_free = !out_valid || out_ready;
    in_ready = (state == S_IDLE);
  end

  // Scan of one way per cycle.
  always_comb begin
    scan_last  = (NW_W'(scan_w) == nw - NW_W'(1));
    scan_match = rd_row.valid[scan_w] && (rd_row.tag[scan_w] == line_cur);
  end

  // Remainder unit: two restoring steps per cycle.
  always_comb begin
    mod_rem_next = mod_rem;
    mod_dvd_next = mod_dvd;
    mod_t        = '0;
    for (int k = 0; k < 2; k++) begin
      mod_t = {mod_rem_next, mod_dvd_next[31]};
      mod_dvd_next = {mod_dvd_next[30:0], 1'b0};
      if (mod_t >= {1'b0, mod_div}) begin
        mod_t = mod_t - {1'b0, mod_div};
      end
      mod_rem_next = mod_t[15:0];
    end
  end

  // Xorshift step for a random victim.
  always_comb begin
    rnd_next = random_state ^ (random_state << 13);
    rnd_next = rnd_next ^ (rnd_next >> 17);
    rnd_next = rnd_next ^ (rnd_next << 5);
  end

  // Row update for the chosen way, and the halved row for decay.
  always_comb begin
    upd_row  = rd_row;
    half_row = rd_row;
    dev      = !hit_f && rd_row.dirty[way_q];
    tw       = is_store && !wb;
    if (hit_f) begin
      if (is_store && wb) begin
        upd_row.dirty[way_q] = 1'b1;
      end
      if (victim_policy == POL_LFU) begin
        if (rd_row.rank[way_q] != '1) begin
          upd_row.rank[way_q] = rd_row.rank[way_q] + 32'd1;
        end
      end else if (victim_policy == POL_LRU) begin
        upd_row.rank[way_q] = reference_count;
      end
    end else begin
      upd_row.valid[way_q] = 1'b1;
      upd_row.tag[way_q]   = line_cur;
      upd_row.dirty[way_q] = is_store && wb;
      if (victim_policy == POL_FIFO || victim_policy == POL_LRU) begin
        upd_row.rank[way_q] = reference_count;
      end else if (victim_policy == POL_LFU) begin
        upd_row.rank[way_q] = '0;
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      half_row.rank[w] = rd_row.rank[w] >> 1;
    end
  end

  // Memory port control.
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = set_q;
    wr_row   = upd_row;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sweep_idx;
        wr_row   = '0;
      end
      S_LREAD: begin
        mem_re   = 1'b1;
        mem_addr = set_tab[set_raw];
      end
      S_UPDATE: begin
        mem_we = out_free;
      end
      S_SWRD: begin
        mem_re   = 1'b1;
        mem_addr = sweep_idx;
      end
      S_SWWR: begin
        mem_we   = 1'b1;
        mem_addr = sweep_idx;
        wr_row   = half_row;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Row memory, one port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_row;
    end
    if (mem_re) begin
      rd_row <= mem[mem_addr];
    end
  end

  // Sequencer, counters, registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_CLEAR;
      sweep_idx          <= '0;
      out_valid          <= 1'b0;
      line_size_log2     <= 3'd5;
      sets_log2          <= 3'd4;
      ways_in_use        <= 4'd2;
      victim_policy      <= POL_LRU;
      wb_mode            <= 1'b1;
      decay_interval     <= 16'd1000;
      reference_count    <= '0;
      hit_count          <= '0;
      miss_count         <= '0;
      read_count         <= '0;
      write_count        <= '0;
      random_state       <= 32'd1;
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_SIZE: line_size_log2     <= cfg_data[2:0];
          CFG_SETS:      sets_log2          <= cfg_data[2:0];
          CFG_WAYS:      ways_in_use        <= cfg_data[3:0];
          CFG_POLICY:    victim_policy      <= cfg_data[1:0];
          CFG_WB_MODE:   wb_mode            <= cfg_data[0];
          CFG_DECAY:     decay_interval     <= cfg_data;
          default:       ;
        endcase
      end

      // The update step reloads the output register itself when it is freed.
      if (out_valid && out_ready && state != S_UPDATE) begin
        out_valid <= 1'b0;
      end

      case (state)
        // Clear valid and dirty bits one set per cycle.
        S_CLEAR: begin
          sweep_idx <= sweep_idx + SET_W'(1);
          if (sweep_idx == SET_W'(MAX_SETS - 1)) begin
            state <= S_IDLE;
          end
        end

        // Take an item and split it into line accesses.
        S_IDLE: begin
          if (in_valid) begin
            kind_q          <= in_data.access_kind;
            line_cur        <= in_l1;
            line_second     <= in_l2;
            last_q          <= (in_l1 == in_l2);
            reference_count <= ref_inc;
            decay_due       <= 1'b0;
            mod_dvd         <= ref_inc;
            mod_div         <= iv;
            mod_rem         <= '0;
            mod_cnt         <= '0;
            state <= (victim_policy == POL_LFU) ? S_DMOD : S_LREAD;
          end
        end

        // Reference count modulo the decay interval.
        S_DMOD: begin
          mod_dvd <= mod_dvd_next;
          mod_rem <= mod_rem_next;
          mod_cnt <= mod_cnt + 4'd1;
          if (mod_cnt == 4'd15) begin
            decay_due <= (mod_rem_next == 16'd0);
            state     <= S_LREAD;
          end
        end

        // Read the set row and reset the scan.
        S_LREAD: begin
          set_q  <= set_tab[set_raw];
          scan_w <= '0;
          hit_f  <= 1'b0;
          inv_f  <= 1'b0;
          state  <= S_SCAN;
        end

        // Look at one way per cycle.
        S_SCAN: begin
          if (!hit_f && scan_match) begin
            hit_f <= 1'b1;
            hit_w <= scan_w;
          end
          if (!inv_f && !rd_row.valid[scan_w]) begin
            inv_f <= 1'b1;
            inv_w <= scan_w;
          end
          if (scan_w == '0 || rd_row.rank[scan_w] < best_rank) begin
            best_rank <= rd_row.rank[scan_w];
            min_w     <= scan_w;
          end
          scan_w <= scan_w + WAY_W'(1);
          if (scan_last) begin
            state <= S_DECIDE;
          end
        end

        // Pick the way.
        S_DECIDE: begin
          if (hit_f) begin
            way_q <= hit_w;
            state <= S_UPDATE;
          end else if (inv_f) begin
            way_q <= inv_w;
            state <= S_UPDATE;
          end else if (victim_policy == POL_RANDOM) begin
            random_state <= rnd_next;
            mod_dvd      <= rnd_next;
            mod_div      <= 16'(nw);
            mod_rem      <= '0;
            mod_cnt      <= '0;
            state        <= S_RMOD;
          end else begin
            way_q <= min_w;
            state <= S_UPDATE;
          end
        end

        // Random value modulo the ways in use.
        S_RMOD: begin
          mod_dvd <= mod_dvd_next;
          mod_rem <= mod_rem_next;
          mod_cnt <= mod_cnt + 4'd1;
          if (mod_cnt == 4'd15) begin
            way_q <= WAY_W'(mod_rem_next);
            state <= S_UPDATE;
          end
        end

        // Write the row back, count and present the result.
        S_UPDATE: begin
          if (out_free) begin
            hit_count   <= hit_count + 32'(hit_f);
            miss_count  <= miss_count + 32'(!hit_f);
            read_count  <= read_count + 32'(!hit_f);
            write_count <= write_count + 32'({dev & tw, dev ^ tw});
            out_valid                   <= 1'b1;
            out_data.line_address       <= line_cur;
            out_data.hit                <= hit_f;
            out_data.way                <= 3'({3'b000, way_q});
            out_data.dirty_eviction     <= dev;
            out_data.through_write      <= tw;
            out_data.last               <= last_q;
            out_data.hit_total          <= hit_count + 32'(hit_f);
            out_data.miss_total         <= miss_count + 32'(!hit_f);
            out_data.memory_read_total  <= read_count + 32'(!hit_f);
            out_data.memory_write_total <= write_count + 32'({dev & tw, dev ^ tw});
            if (victim_policy == POL_LFU && decay_due) begin
              sweep_idx <= '0;
              state     <= S_SWRD;
            end else if (!last_q) begin
              line_cur <= line_second;
              last_q   <= 1'b1;
              state    <= S_LREAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        // Decay sweep: read a row.
        S_SWRD: begin
          state <= S_SWWR;
        end

        // Decay sweep: write the halved ranks back.
        S_SWWR: begin
          sweep_idx <= sweep_idx + SET_W'(1);
          if (sweep_idx != SET_W'(MAX_SETS - 1)) begin
            state <= S_SWRD;
          end else if (!last_q) begin
            line_cur <= line_second;
            last_q   <= 1'b1;
            state    <= S_LREAD;
          end else begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/sacm_checker.sv
// ----------------------------------------------------------------------------
// Set-associative cache model port checker
// Watches the top-level ports and flags results that break the cache rules.
// ----------------------------------------------------------------------------
`include "set_associative_cache_model_top_macros.svh"

module sacm_checker
  import sacm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled result stays put.
  `SACM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // An accepted item leaves the block busy in the cycle after it is taken.
  `SACM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A hit never evicts a line.
  `SACM_ASSERT_NOW(a_hit_no_evict, out_valid && out_data.hit, !out_data.dirty_eviction)

endmodule

bind set_associative_cache_model_top sacm_checker u_sacm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
